// ===== rtl/abbi_pkg.sv =====
// Package for the adaptive block bit inverter.
// Holds the pattern codes, the register indexes and the shared result type.
// No dependencies.
`timescale 1ns / 1ps

package abbi_pkg;

  // default largest block, in bits
  localparam int MaxBlockDefault = 1024;

  // fixed field widths
  localparam int BlockSizeW = 11;
  localparam int CfgDataW   = 11;
  localparam int CfgIndexW  = 1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_BLOCK_SIZE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_DIRECTION  = 1'b1;

  // reset values of the configuration registers
  localparam logic [BlockSizeW-1:0] BlockSizeReset = 11'd4;

  // inversion pattern for the current block
  typedef enum logic [1:0] {
    MODE_ALL   = 2'd0,
    MODE_ODD   = 2'd1,
    MODE_THIRD = 2'd2
  } mode_e;

  // one coded bit as it leaves the coder
  typedef struct packed {
    logic coded_bit;
    logic block_end;
  } result_t;

endpackage

// ===== rtl/abbi_coder.sv =====
// Per-bit coder of the adaptive block bit inverter: block position, plaintext
// counts and the inversion pattern chosen at each block end.
// Depends on abbi_pkg.
`timescale 1ns / 1ps

module abbi_coder #(
  parameter int MaxBlock = abbi_pkg::MaxBlockDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             data_bit_i,
  input  logic                             stream_start_i,
  input  logic [abbi_pkg::BlockSizeW-1:0]  block_size_i,
  input  logic                             direction_i,
  output abbi_pkg::result_t                result_o
);

  import abbi_pkg::*;

  localparam int PosW  = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;
  localparam int CntW  = $clog2(MaxBlock + 1);
  localparam int SzRaw = $clog2(MaxBlock + 1);
  localparam int SzW   = (SzRaw > BlockSizeW) ? SzRaw : BlockSizeW;

  localparam logic [SzW-1:0] MaxSize = SzW'(MaxBlock);

  logic [PosW-1:0] pos_q, pos_d, pos_cur;
  logic [1:0]      phase_q, phase_d, phase_cur;
  logic [CntW-1:0] ones_q, ones_d, ones_cur, ones_n;
  logic [CntW-1:0] zeros_q, zeros_d, zeros_cur, zeros_n;
  mode_e           mode_q, mode_d, mode_cur;

  logic [SzW-1:0] size_ext, size_eff, pos_next_ext;
  logic           invert, coded, plain, closes;

  // a new stream restarts the block with everything inverted
  always_comb begin
    if (stream_start_i) begin
      pos_cur   = '0;
      phase_cur = 2'd0;
      ones_cur  = '0;
      zeros_cur = '0;
      mode_cur  = MODE_ALL;
    end else begin
      pos_cur   = pos_q;
      phase_cur = phase_q;
      ones_cur  = ones_q;
      zeros_cur = zeros_q;
      mode_cur  = mode_q;
    end
  end

  // effective block size, clamped to 1..MaxBlock
  always_comb begin
    size_ext = SzW'(block_size_i);
    if (size_ext == '0) begin
      size_eff = SzW'(1);
    end else if (size_ext > MaxSize) begin
      size_eff = MaxSize;
    end else begin
      size_eff = size_ext;
    end
  end

  // pattern lookup, phase holds the position modulo three
  always_comb begin
    case (mode_cur)
      MODE_ODD:   invert = pos_cur[0];
      MODE_THIRD: invert = (phase_cur == 2'd2);
      default:    invert = 1'b1;
    endcase
  end

  assign coded        = data_bit_i ^ invert;
  assign plain        = direction_i ? coded : data_bit_i;
  assign ones_n       = ones_cur + CntW'(plain);
  assign zeros_n      = zeros_cur + CntW'(!plain);
  assign pos_next_ext = SzW'(pos_cur) + SzW'(1);
  assign closes       = (pos_next_ext >= size_eff);

  // next state: advance in the block or pick the next pattern
  always_comb begin
    if (closes) begin
      pos_d   = '0;
      phase_d = 2'd0;
      ones_d  = '0;
      zeros_d = '0;
      if (zeros_n == ones_n) begin
        mode_d = MODE_ALL;
      end else if (zeros_n > ones_n) begin
        mode_d = MODE_ODD;
      end else begin
        mode_d = MODE_THIRD;
      end
    end else begin
      pos_d   = pos_cur + PosW'(1);
      phase_d = (phase_cur == 2'd2) ? 2'd0 : phase_cur + 2'd1;
      ones_d  = ones_n;
      zeros_d = zeros_n;
      mode_d  = mode_cur;
    end
  end

  assign result_o.coded_bit = coded;
  assign result_o.block_end = closes;

  // coder state, updated once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 2'd0;
      ones_q  <= '0;
      zeros_q <= '0;
      mode_q  <= MODE_ALL;
    end else if (step_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      ones_q  <= ones_d;
      zeros_q <= zeros_d;
      mode_q  <= mode_d;
    end
  end

endmodule

// ===== rtl/adaptive_block_bit_inverter.sv =====
// Top level of the adaptive block bit inverter.
// Holds the configuration registers and the result register around abbi_coder.
// Depends on abbi_pkg and abbi_coder.
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid_i / in_ready_o) carries one stream bit per request,
//   with stream_start_i high on the first bit of a new stream
// - output channel (out_valid_o / out_ready_i) returns the coded bit and a
//   flag that marks the last bit of each block
// - the coded bit is registered: a bit accepted at a clock edge is shown on the
//   outputs after that edge; throughput is one bit per cycle while the receiver
//   is ready; the per-bit path is the position compare, the pattern select and
//   the count update in abbi_coder; the result register is refilled in the same
//   cycle it is emptied, so a ready receiver never causes a bubble
// - when the receiver stalls, in_ready_o drops while a result waits, and the
//   result holds until it is taken
// - reset clears the block position, the counts and the output valid, and
//   sets the first-block pattern to invert all bits; block_size returns to 4
//   and direction to encode
// - cfg_we_i writes block_size (index 0) or direction (index 1) at the edge;
//   write only while no bit is in flight
module adaptive_block_bit_inverter #(
  parameter int MaxBlock = abbi_pkg::MaxBlockDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            data_bit_i,
  input  logic                            stream_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            coded_bit_o,
  output logic                            block_end_o,
  input  logic                            cfg_we_i,
  input  logic [abbi_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [abbi_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  import abbi_pkg::*;

  logic [BlockSizeW-1:0] block_size_q;
  logic                  direction_q;
  logic                  out_valid_q;
  result_t               result_d, result_q;
  logic                  accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeReset;
      direction_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLOCK_SIZE: block_size_q <= cfg_wdata_i[BlockSizeW-1:0];
        CFG_DIRECTION:  direction_q  <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // take a request whenever the result register is empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  abbi_coder #(
    .MaxBlock(MaxBlock)
  ) u_coder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .data_bit_i    (data_bit_i),
    .stream_start_i(stream_start_i),
    .block_size_i  (block_size_q),
    .direction_i   (direction_q),
    .result_o      (result_d)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coded_bit_o = result_q.coded_bit;
  assign block_end_o = result_q.block_end;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for adaptive_block_bit_inverter.
// Drives random and directed bit streams through both channels and checks every coded bit
// against a cycle-free model of the ones-versus-zeros block inversion rule. Depends on abbi_pkg.
`timescale 1ns / 1ps

module tb;
  import abbi_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int MaxPrinted    = 40;
  localparam int SmallTarget   = 400;
  localparam int LongHold      = 250;

  typedef struct packed {
    logic data_bit;
    logic stream_start;
  } bit_req_t;

  // clock, reset and block ports
  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready_o;
  logic                 in_bit    = 1'b0;
  logic                 in_start  = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic                 coded_bit_o;
  logic                 block_end_o;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = CFG_BLOCK_SIZE;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  // model copy of the registers and the coder state
  logic [BlockSizeW-1:0] size_reg  = BlockSizeReset;
  logic                  dir_reg   = 1'b0;
  logic [9:0]            pos_now   = '0;
  logic [10:0]           ones_now  = '0;
  logic [10:0]           zeros_now = '0;
  mode_e                 mode_now  = MODE_ALL;

  bit_req_t stim_q[$];
  result_t  coded_q[$];

  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_restart = 0;
  int n_phase = 0;
  int mode_hits [0:2] = '{0, 0, 0};
  int tx_gap = 0;
  int rx_hold = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit long_hold_done = 1'b0;

  adaptive_block_bit_inverter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .data_bit_i     (in_bit),
    .stream_start_i (in_start),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .coded_bit_o    (coded_bit_o),
    .block_end_o    (block_end_o),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // next coded bit; advances the model state
  function automatic result_t code_bit(input logic d, input logic s);
    int unsigned eff;
    logic        flip;
    logic        plain;
    result_t     res;
    if (s) begin
      pos_now   = '0;
      ones_now  = '0;
      zeros_now = '0;
      mode_now  = MODE_ALL;
      n_restart++;
    end
    if (size_reg == 0) eff = 1;
    else if (size_reg > MaxBlockDefault) eff = MaxBlockDefault;
    else eff = size_reg;
    case (mode_now)
      MODE_ODD:   flip = pos_now[0];
      MODE_THIRD: flip = (pos_now % 3 == 2);
      default:    flip = 1'b1;
    endcase
    res.coded_bit = d ^ flip;
    // plaintext is the input when encoding, the output when decoding
    plain = dir_reg ? res.coded_bit : d;
    if (plain) ones_now++;
    else zeros_now++;
    res.block_end = (pos_now + 1 >= eff);
    if (res.block_end) begin
      if (zeros_now == ones_now) mode_now = MODE_ALL;
      else if (zeros_now > ones_now) mode_now = MODE_ODD;
      else mode_now = MODE_THIRD;
      mode_hits[mode_now]++;
      pos_now   = '0;
      ones_now  = '0;
      zeros_now = '0;
    end else begin
      pos_now++;
    end
    return res;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    n_err++;
    if (n_err <= MaxPrinted) $display("mismatch: %s", msg);
  endtask

  // fixed bit pattern, listed first bit on the left
  task automatic queue_bits(input int n, input logic [15:0] bits, input logic [15:0] starts);
    bit_req_t req;
    @(negedge clk_i);
    quiet = 1'b0;
    for (int i = n - 1; i >= 0; i--) begin
      req.data_bit     = bits[i];
      req.stream_start = starts[i];
      stim_q.push_back(req);
    end
  endtask

  // random phase: biased data, rare restarts, now and then a noisy one
  task automatic queue_phase(input int unsigned count);
    int unsigned bias;
    int unsigned one_pct;
    int unsigned start_pct;
    bit_req_t    req;
    @(negedge clk_i);
    quiet     = ($urandom_range(0, 3) == 0);
    bias      = $urandom_range(0, 2);
    one_pct   = (bias == 0) ? 50 : (bias == 1) ? 20 : 80;
    start_pct = ($urandom_range(0, 9) == 0) ? 30 : 2;
    for (int unsigned i = 0; i < count; i++) begin
      req.data_bit     = ($urandom_range(0, 99) < one_pct);
      req.stream_start = ($urandom_range(0, 99) < start_pct) ||
                         (i == 0 && $urandom_range(0, 3) == 0);
      stim_q.push_back(req);
    end
  endtask

  // wait until every request is in and every coded bit is out
  task automatic drain_wait();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid || coded_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) size_reg = val[BlockSizeW-1:0];
    else dir_reg = val[0];
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_proc
    bit_req_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready_o)) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (stim_q.size() != 0) begin
        req = stim_q.pop_front();
        in_valid <= 1'b1;
        in_bit   <= req.data_bit;
        in_start <= req.stream_start;
        tx_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (hold_request && !long_hold_done) begin
      long_hold_done <= 1'b1;
      out_ready      <= 1'b0;
      rx_hold        <= LongHold;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_hold   <= pick_gap();
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin : check_proc
    result_t want;
    logic    moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        n_out++;
        if (coded_q.size() == 0) begin
          report_mismatch($sformatf("coded bit %0d arrived with nothing pending", n_out));
        end else begin
          want = coded_q.pop_front();
          if (coded_bit_o !== want.coded_bit)
            report_mismatch($sformatf("bit %0d coded_bit got %b want %b",
                                      n_out, coded_bit_o, want.coded_bit));
          if (block_end_o !== want.block_end)
            report_mismatch($sformatf("bit %0d block_end got %b want %b",
                                      n_out, block_end_o, want.block_end));
        end
      end
      if (in_valid && in_ready_o) begin
        moved = 1'b1;
        coded_q.push_back(code_bit(in_bit, in_start));
        n_in <= n_in + 1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL adaptive_block_bit_inverter");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin : main_proc
    int unsigned n_small;
    int unsigned sz;
    int unsigned cnt;
    int unsigned r;
    n_small = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: equal, zero-heavy and one-heavy blocks, then a restart mid-block
    queue_bits(16, 16'b1010_0001_1110_1101, 16'b1000_0000_0000_0010);
    drain_wait();
    // size zero acts as one, decode
    write_reg(CFG_BLOCK_SIZE, 0);
    write_reg(CFG_DIRECTION, 1);
    queue_bits(4, 16'b1011, 16'b0000);
    drain_wait();
    // oversize clamps to the largest block, encode
    write_reg(CFG_BLOCK_SIZE, 2047);
    write_reg(CFG_DIRECTION, 0);
    queue_bits(6, 16'b110010, 16'b100000);
    drain_wait();
    // size lowered below the current position closes the block at once
    write_reg(CFG_BLOCK_SIZE, 3);
    queue_bits(3, 16'b011, 16'b000);
    drain_wait();

    // random phases, mostly small blocks, a few at the extremes
    while (n_small < SmallTarget) begin
      r = $urandom_range(0, 99);
      if (n_phase == 1) begin
        sz  = 1;
        cnt = 40;
      end else if (n_phase == 2) begin
        sz  = MaxBlockDefault;
        cnt = MaxBlockDefault + 6;
      end else if (n_phase == 5) begin
        sz  = 2047;
        cnt = 40;
      end else begin
        if (r < 5) sz = 0;
        else if (r < 70) sz = $urandom_range(1, 8);
        else if (r < 92) sz = $urandom_range(9, 40);
        else sz = $urandom_range(41, 200);
        cnt = $urandom_range(20, 80);
        n_small += cnt;
      end
      if (n_phase < 6 || $urandom_range(0, 4) != 0) write_reg(CFG_BLOCK_SIZE, sz);
      if ($urandom_range(0, 99) < 60) write_reg(CFG_DIRECTION, $urandom_range(0, 1));
      queue_phase(cnt);
      // long receiver hold-off while the big phase keeps the sender busy
      if (n_phase == 2) hold_request = 1'b1;
      drain_wait();
      n_phase++;
    end

    repeat (4) @(posedge clk_i);
    if (coded_q.size() != 0)
      report_mismatch($sformatf("%0d coded bits never arrived", coded_q.size()));
    $display("run covered %0d coded bits in %0d random phases, %0d stream restarts",
             n_out, n_phase, n_restart);
    $display("block patterns chosen: invert all %0d, odd positions %0d, every third %0d",
             mode_hits[0], mode_hits[1], mode_hits[2]);
    if (n_err == 0) begin
      $display("PASS adaptive_block_bit_inverter");
    end else begin
      $display("FAIL adaptive_block_bit_inverter");
    end
    $finish;
  end

endmodule
